>>> src/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; every other file of the block uses this package.
package lpfd_pkg;

	// Frame buffer size; the body length may not exceed BUFFER_BYTES - 1.
	localparam int unsigned BUFFER_BYTES = 512;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned OFS_W = 9;
	localparam logic [LEN_W-1:0] BUF_MAX_LEN = LEN_W'(BUFFER_BYTES - 1);

	// Configuration register file.
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;
	localparam logic [7:0] HEADER_RST = 8'h3A;
	localparam logic [7:0] STOP_RST = 8'h0A;
	localparam logic [OFS_W-1:0] LIMIT_RST = 9'd511;

	typedef enum logic [1:0] {
		REG_HEADER = 2'd0,
		REG_STOP   = 2'd1,
		REG_LIMIT  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_BODY = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2,
		KIND_LONG = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0]       header_byte;
		logic [7:0]       stop_byte;
		logic [OFS_W-1:0] length_limit;
	} cfg_t;

endpackage

>>> src/lpfd_if.sv
// Valid/ready channel interfaces for received bytes and deframer results.
// Depends on lpfd_pkg for the result kind type and field widths.
interface lpfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpfd_out_if;
	logic                        valid;
	logic                        ready;
	lpfd_pkg::kind_t             kind;
	logic [7:0]                  body_byte;
	logic [lpfd_pkg::OFS_W-1:0]  body_offset;

	modport source (output valid, output kind, output body_byte, output body_offset,
		input ready);
	modport sink (input valid, input kind, input body_byte, input body_offset,
		output ready);
endinterface

>>> src/lpfd_cfg.sv
// APB-style configuration registers: header byte, stop byte, length limit.
// Depends on lpfd_pkg for the register indexes, reset values and cfg_t.
module lpfd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpfd_pkg::ADDR_W-1:0]   paddr,
	input  logic [lpfd_pkg::DATA_W-1:0]   pwdata,
	output logic [lpfd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output lpfd_pkg::cfg_t                cfg
);
	import lpfd_pkg::*;

	logic [7:0]       header_q;
	logic [7:0]       stop_q;
	logic [OFS_W-1:0] limit_q;
	logic [1:0]       idx;
	logic             wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RST;
			stop_q   <= STOP_RST;
			limit_q  <= LIMIT_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_HEADER: header_q <= pwdata[7:0];
				REG_STOP:   stop_q   <= pwdata[7:0];
				REG_LIMIT:  limit_q  <= pwdata[OFS_W-1:0];
				default: begin
					// Writes past the register list are dropped.
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_HEADER: prdata = DATA_W'(header_q);
			REG_STOP:   prdata = DATA_W'(stop_q);
			REG_LIMIT:  prdata = DATA_W'(limit_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.header_byte  = header_q;
	assign cfg.stop_byte    = stop_q;
	assign cfg.length_limit = limit_q;

endmodule

>>> src/lpfd_core.sv
// Deframer datapath: input byte register, frame state machine, result register.
// Depends on lpfd_pkg and the lpfd_in_if / lpfd_out_if channel interfaces.
module lpfd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  lpfd_pkg::cfg_t cfg,
	lpfd_in_if.sink        in_ch,
	lpfd_out_if.source     out_ch
);
	import lpfd_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT   = 2'd0,
		PH_LEN_HI = 2'd1,
		PH_LEN_LO = 2'd2,
		PH_BODY   = 2'd3
	} phase_t;

	logic             valid_s1;
	logic [7:0]       rx_byte_s1;

	phase_t           phase_q;
	logic [7:0]       len_hi_q;
	logic [OFS_W-1:0] remaining_q;
	logic [OFS_W-1:0] offset_q;

	logic             out_valid_q;
	kind_t            kind_q;
	logic [7:0]       body_byte_q;
	logic [OFS_W-1:0] body_offset_q;

	// Next-state and result decode for the byte held in the input register.
	phase_t           phase_d;
	logic [OFS_W-1:0] remaining_d;
	logic [OFS_W-1:0] offset_d;
	logic             has_res;
	kind_t            res_kind;
	logic [7:0]       res_byte;
	logic [OFS_W-1:0] res_offset;
	logic [LEN_W-1:0] frame_len;
	logic [LEN_W-1:0] cap;
	logic             out_free;
	logic             fire;

	assign frame_len = {len_hi_q, rx_byte_s1};
	assign cap = (LEN_W'(cfg.length_limit) > BUF_MAX_LEN) ? BUF_MAX_LEN
		: LEN_W'(cfg.length_limit);

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		offset_d    = offset_q;
		has_res     = 1'b0;
		res_kind    = KIND_BODY;
		res_byte    = '0;
		res_offset  = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte_s1 == cfg.header_byte) begin
					phase_d = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				offset_d = '0;
				if (frame_len > cap) begin
					remaining_d = '0;
					phase_d     = PH_HUNT;
					has_res     = 1'b1;
					res_kind    = KIND_LONG;
				end else begin
					// The cap never exceeds the offset range, so the low bits hold it all.
					remaining_d = frame_len[OFS_W-1:0];
					phase_d     = PH_BODY;
				end
			end
			PH_BODY: begin
				has_res = 1'b1;
				if (remaining_q == '0) begin
					res_kind   = (rx_byte_s1 == cfg.stop_byte) ? KIND_GOOD : KIND_BAD;
					res_offset = offset_q;
					offset_d   = '0;
					phase_d    = PH_HUNT;
				end else begin
					res_kind    = KIND_BODY;
					res_byte    = rx_byte_s1;
					res_offset  = offset_q;
					remaining_d = remaining_q - 1'b1;
					offset_d    = offset_q + 1'b1;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// A byte that yields no result moves on even while the result register is full.
	assign out_free    = !out_valid_q || out_ch.ready;
	assign fire        = valid_s1 && (!has_res || out_free);
	assign in_ch.ready = !valid_s1 || fire;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			rx_byte_s1 <= in_ch.rx_byte;
		end
		if (fire && phase_q == PH_LEN_HI) begin
			len_hi_q <= rx_byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			phase_q       <= PH_HUNT;
			remaining_q   <= '0;
			offset_q      <= '0;
			out_valid_q   <= 1'b0;
			kind_q        <= KIND_BODY;
			body_byte_q   <= '0;
			body_offset_q <= '0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (fire) begin
				phase_q     <= phase_d;
				remaining_q <= remaining_d;
				offset_q    <= offset_d;
			end
			if (fire && has_res) begin
				out_valid_q   <= 1'b1;
				kind_q        <= res_kind;
				body_byte_q   <= res_byte;
				body_offset_q <= res_offset;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.kind        = kind_q;
	assign out_ch.body_byte   = body_byte_q;
	assign out_ch.body_offset = body_offset_q;

	// Offset plus bytes still due is the accepted body length, which fits the cap.
	a_body_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |->
			({1'b0, offset_q} + {1'b0, remaining_q}) <= (OFS_W + 1)'(BUF_MAX_LEN))
		else $error("body offset and remaining count exceed the buffer");

	a_long_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_LONG |-> body_offset_q == '0 && body_byte_q == '0)
		else $error("length error result carries nonzero fields");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_BODY |-> body_byte_q == '0)
		else $error("frame end result carries a body byte");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(rx_byte_s1) && $stable(phase_q))
		else $error("stalled input byte was lost or state moved");

	a_body_res: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_BODY |=> out_valid_q)
		else $error("body phase byte produced no result");

endmodule

>>> src/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer top level: config registers and deframer core.
// Path: an accepted byte goes to the input register, then its result to the result register.
// Throughput: one byte per cycle; the input stalls only while a result is held
// by out_ch.ready and the byte in the input register would produce another one.
// Reset: arst_n clears to hunt, registers return to header 0x3A, stop 0x0A, limit 511.
module length_prefixed_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	lpfd_in_if.sink                       in_ch,
	lpfd_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpfd_pkg::ADDR_W-1:0]   paddr,
	input  logic [lpfd_pkg::DATA_W-1:0]   pwdata,
	output logic [lpfd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import lpfd_pkg::*;

	cfg_t cfg;

	lpfd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lpfd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule
